// File: sv/morph_delta_accumulator_unit_defines.svh
// Assertion macros for the morph delta accumulator.
// Used by the top level only; no other dependencies.
`ifndef MORPH_DELTA_ACCUMULATOR_UNIT_DEFINES_SVH
`define MORPH_DELTA_ACCUMULATOR_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define MDA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MDA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MDA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MDA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: sv/mda_pkg.sv
// Shared types and codes for the morph delta accumulator.
// No dependencies.
package mda_pkg;

  localparam int unsigned CountW = 13;
  localparam int unsigned WeightW = 24;
  localparam int unsigned PaddrW = 4;

  localparam logic [1:0] OpLoad  = 2'd0;
  localparam logic [1:0] OpApply = 2'd1;
  localparam logic [1:0] OpRead  = 2'd2;

  localparam logic [1:0] StatOk  = 2'd0;
  localparam logic [1:0] StatOob = 2'd1;
  localparam logic [1:0] StatSat = 2'd2;

  localparam logic [1:0] RegPackedMode  = 2'd0;
  localparam logic [1:0] RegMorphWeight = 2'd1;
  localparam logic [1:0] RegPackedScale = 2'd2;
  localparam logic [1:0] RegVertexCount = 2'd3;

  typedef struct packed {
    logic [1:0]         operation;
    logic [15:0]        vertex_index;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
    logic signed [31:0] z_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] x_out;
    logic signed [31:0] y_out;
    logic signed [31:0] z_out;
    logic [1:0]         status;
  } out_item_t;

  typedef enum logic [2:0] {
    StIdle, StRead, StDecide, StScale, StMul, StAcc, StWrite, StDone
  } state_e;

  typedef struct packed {
    logic       capture;
    logic       decide;
    logic       scale;
    logic       mul;
    logic       acc;
    logic       write;
    logic       emit;
    logic [1:0] coord;
  } cmd_t;

  typedef struct packed {
    logic       oob;
    logic [1:0] operation;
    logic       out_free;
  } stat_t;

endpackage

// File: sv/morph_delta_accumulator_unit.sv
// Channel   Direction  Handshake          Payload
// in        input      in_valid/in_stall  mda_pkg::in_item_t
// out       output     out_valid/out_stall mda_pkg::out_item_t
// cfg       input      APB (psel/penable) 32-bit registers at 4*i
// A skipped or read item passes only the memory read, a loaded item adds the write,
// and a delta takes one memory read, then per coordinate a scale multiply,
// a weight multiply and a saturating add on the shared multiplier pair, then the write.
// The output register frees the result side: a new item is taken once the
// previous one is handed to the output register. No clearing pass after reset.
// Top level: APB registers, controller, datapath. Depends on mda_pkg,
// mda_ctrl, mda_datapath and the defines header.
`include "morph_delta_accumulator_unit_defines.svh"
module morph_delta_accumulator_unit #(
  parameter int unsigned VERTEX_DEPTH = 4096
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  mda_pkg::in_item_t          in_item_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output mda_pkg::out_item_t         out_item_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mda_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic                               packed_mode_q;
  logic signed [mda_pkg::WeightW-1:0] weight_q;
  logic [31:0]                        scale_q;
  logic [mda_pkg::CountW-1:0]         count_q;
  mda_pkg::cmd_t                      cmd;
  mda_pkg::stat_t                     stat;
  logic                               wr_en;
  logic                               out_oob;
  logic                               out_zero;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      packed_mode_q <= 1'b0;
      weight_q      <= '0;
      scale_q       <= '0;
      count_q       <= '0;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        mda_pkg::RegPackedMode:  packed_mode_q <= pwdata[0];
        mda_pkg::RegMorphWeight: weight_q <= pwdata[mda_pkg::WeightW-1:0];
        mda_pkg::RegPackedScale: scale_q <= pwdata;
        mda_pkg::RegVertexCount: count_q <= pwdata[mda_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      mda_pkg::RegPackedMode:  prdata = {31'd0, packed_mode_q};
      mda_pkg::RegMorphWeight: prdata = {{(32 - mda_pkg::WeightW){1'b0}}, weight_q};
      mda_pkg::RegPackedScale: prdata = scale_q;
      mda_pkg::RegVertexCount: prdata = {{(32 - mda_pkg::CountW){1'b0}}, count_q};
      default:                 prdata = '0;
    endcase
  end

  mda_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mda_datapath #(
    .VERTEX_DEPTH (VERTEX_DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .in_item_i     (in_item_i),
    .packed_mode_i (packed_mode_q),
    .weight_i      (weight_q),
    .scale_i       (scale_q),
    .count_i       (count_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_item_o    (out_item_o)
  );

  assign out_oob  = (out_item_o.status == mda_pkg::StatOob);
  assign out_zero = (out_item_o.x_out == 32'sd0) && (out_item_o.y_out == 32'sd0) &&
                    (out_item_o.z_out == 32'sd0);

  `MDA_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `MDA_ASSERT_IMP(a_status_code, clk_i, rst_ni, out_valid_o, out_item_o.status != 2'd3)
  `MDA_ASSERT_IMP(a_oob_zero, clk_i, rst_ni, out_valid_o && out_oob, out_zero)

endmodule

// File: sv/mda_ctrl.sv
// Controller state machine for the morph delta accumulator.
// Depends on mda_pkg.
module mda_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  mda_pkg::stat_t stat_i,
  output mda_pkg::cmd_t  cmd_o
);

  mda_pkg::state_e state_q, state_d;
  logic [1:0]      coord_q, coord_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mda_pkg::StIdle;
      coord_q <= 2'd0;
    end else begin
      state_q <= state_d;
      coord_q <= coord_d;
    end
  end

  always_comb begin
    state_d = state_q;
    coord_d = coord_q;
    cmd_o = '0;
    cmd_o.coord = coord_q;
    in_stall_o = 1'b1;
    unique case (state_q)
      mda_pkg::StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = mda_pkg::StRead;
        end
      end
      mda_pkg::StRead: state_d = mda_pkg::StDecide;
      mda_pkg::StDecide: begin
        cmd_o.decide = 1'b1;
        coord_d = 2'd0;
        if (stat_i.oob) begin
          state_d = mda_pkg::StDone;
        end else if (stat_i.operation == mda_pkg::OpLoad) begin
          state_d = mda_pkg::StWrite;
        end else if (stat_i.operation == mda_pkg::OpApply) begin
          state_d = mda_pkg::StScale;
        end else begin
          state_d = mda_pkg::StDone;
        end
      end
      mda_pkg::StScale: begin
        cmd_o.scale = 1'b1;
        state_d = mda_pkg::StMul;
      end
      mda_pkg::StMul: begin
        cmd_o.mul = 1'b1;
        state_d = mda_pkg::StAcc;
      end
      mda_pkg::StAcc: begin
        cmd_o.acc = 1'b1;
        if (coord_q == 2'd2) begin
          state_d = mda_pkg::StWrite;
        end else begin
          coord_d = coord_q + 2'd1;
          state_d = mda_pkg::StScale;
        end
      end
      mda_pkg::StWrite: begin
        cmd_o.write = 1'b1;
        state_d = mda_pkg::StDone;
      end
      mda_pkg::StDone: begin
        // hold until the output register can take the item
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = mda_pkg::StIdle;
        end
      end
      default: state_d = mda_pkg::StIdle;
    endcase
  end

endmodule

// File: sv/mda_datapath.sv
// Datapath for the morph delta accumulator: vertex memory, scale and
// weight multipliers, saturating adder and output register. Depends on mda_pkg.
module mda_datapath #(
  parameter int unsigned VERTEX_DEPTH = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mda_pkg::cmd_t                cmd_i,
  output mda_pkg::stat_t               stat_o,
  input  mda_pkg::in_item_t            in_item_i,
  input  logic                         packed_mode_i,
  input  logic signed [mda_pkg::WeightW-1:0] weight_i,
  input  logic [31:0]                  scale_i,
  input  logic [mda_pkg::CountW-1:0]   count_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output mda_pkg::out_item_t           out_item_o
);

  localparam int unsigned AddrW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
  localparam logic [16:0] DepthL = 17'(VERTEX_DEPTH);

  logic [95:0]        mem [VERTEX_DEPTH];
  logic [95:0]        rdata_q;
  logic [AddrW-1:0]   addr_q;
  logic [1:0]         op_q;
  logic               oob_q;
  logic signed [31:0] in_q  [3];
  logic signed [31:0] res_q [3];
  logic [1:0]         status_q;
  logic signed [39:0] scaled_q;
  logic signed [47:0] inc_q;
  logic               out_valid_q;
  mda_pkg::out_item_t out_q;

  logic [16:0]        limit;
  logic signed [31:0] coord_in, coord_old;
  logic signed [15:0] d16;
  logic signed [48:0] sprod, sround;
  logic signed [39:0] scaled_d;
  logic signed [63:0] wprod, wround;
  logic signed [48:0] sum;
  logic signed [31:0] sum_sat;
  logic               sat;

  assign limit = ({4'd0, count_i} < DepthL) ? {4'd0, count_i} : DepthL;
  assign coord_in  = in_q[cmd_i.coord];
  assign coord_old = res_q[cmd_i.coord];

  // packed delta: int16 times unsigned Q8.24, round back to Q16.16
  assign d16 = coord_in[15:0];
  assign sprod = d16 * $signed({1'b0, scale_i});
  assign sround = sprod + 49'sd128;
  assign scaled_d = packed_mode_i ? sround[47:8] : {{8{coord_in[31]}}, coord_in};

  assign wprod = scaled_q * weight_i;
  assign wround = wprod + 64'sd32768;

  assign sum = {{17{coord_old[31]}}, coord_old} + {inc_q[47], inc_q};
  always_comb begin
    sat = 1'b0;
    sum_sat = sum[31:0];
    if (!sum[48] && (sum[47:31] != 17'd0)) begin
      sat = 1'b1;
      sum_sat = 32'sh7fffffff;
    end else if (sum[48] && (sum[47:31] != 17'h1ffff)) begin
      sat = 1'b1;
      sum_sat = 32'sh80000000;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[addr_q];
    if (cmd_i.write) begin
      mem[addr_q] <= {res_q[2], res_q[1], res_q[0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      addr_q <= in_item_i.vertex_index[AddrW-1:0];
      op_q   <= in_item_i.operation;
      oob_q  <= ({1'b0, in_item_i.vertex_index} >= limit);
      in_q[0] <= in_item_i.x_value;
      in_q[1] <= in_item_i.y_value;
      in_q[2] <= in_item_i.z_value;
    end
    if (cmd_i.decide) begin
      if (oob_q) begin
        status_q <= mda_pkg::StatOob;
        for (int i = 0; i < 3; i++) res_q[i] <= '0;
      end else if (op_q == mda_pkg::OpLoad) begin
        status_q <= mda_pkg::StatOk;
        for (int i = 0; i < 3; i++) res_q[i] <= in_q[i];
      end else begin
        status_q <= mda_pkg::StatOk;
        res_q[0] <= rdata_q[31:0];
        res_q[1] <= rdata_q[63:32];
        res_q[2] <= rdata_q[95:64];
      end
    end
    if (cmd_i.scale) scaled_q <= scaled_d;
    if (cmd_i.mul) inc_q <= wround[63:16];
    if (cmd_i.acc) begin
      res_q[cmd_i.coord] <= sum_sat;
      if (sat) status_q <= mda_pkg::StatSat;
    end
    if (cmd_i.emit) begin
      out_q.x_out  <= res_q[0];
      out_q.y_out  <= res_q[1];
      out_q.z_out  <= res_q[2];
      out_q.status <= status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign stat_o.oob = oob_q;
  assign stat_o.operation = op_q;
  assign stat_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o = out_q;

endmodule

// File: dv/morph_delta_accumulator_unit_tb.sv
// Self-checking bench for morph_delta_accumulator_unit: directed table, then random
// load/apply/read traffic under several register settings with bursty input and stalls.
// Depends on mda_pkg and the block's RTL only.
module morph_delta_accumulator_unit_tb;

  localparam int unsigned Depth = 4096;
  localparam int unsigned WatchLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  mda_pkg::in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  mda_pkg::out_item_t out_item_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [mda_pkg::PaddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  morph_delta_accumulator_unit #(.VERTEX_DEPTH(Depth)) uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [31:0] vert_mem [Depth][3];
  bit vert_loaded [Depth];
  logic cfg_packed;
  logic signed [23:0] cfg_weight;
  logic [31:0] cfg_scale;
  logic [12:0] cfg_count;

  mda_pkg::out_item_t expected_q[$];
  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_sat = 0;
  int n_oob = 0;
  int idle_cycles = 0;
  bit hold_out = 1'b0;
  bit send_now = 1'b0;

  function automatic longint rshift_round(longint x, int s);
    return (x + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic mda_pkg::out_item_t morph_step(mda_pkg::in_item_t it);
    mda_pkg::out_item_t r;
    longint lim, d, inc, sum;
    logic [31:0] v [3];
    r = '0;
    lim = (cfg_count < Depth) ? cfg_count : Depth;
    if (it.vertex_index >= lim) begin
      r.status = mda_pkg::StatOob;
      return r;
    end
    v[0] = it.x_value;
    v[1] = it.y_value;
    v[2] = it.z_value;
    if (it.operation == mda_pkg::OpLoad) begin
      for (int j = 0; j < 3; j++) vert_mem[it.vertex_index][j] = v[j];
      vert_loaded[it.vertex_index] = 1'b1;
    end else if (it.operation == mda_pkg::OpApply) begin
      for (int j = 0; j < 3; j++) begin
        if (cfg_packed) begin
          d = rshift_round(longint'($signed(v[j][15:0])) * longint'(cfg_scale), 8);
        end else begin
          d = longint'($signed(v[j]));
        end
        inc = rshift_round(d * longint'(cfg_weight), 16);
        sum = longint'($signed(vert_mem[it.vertex_index][j])) + inc;
        if (sum > 64'sd2147483647) begin
          sum = 64'sd2147483647;
          r.status = mda_pkg::StatSat;
        end
        if (sum < -64'sd2147483648) begin
          sum = -64'sd2147483648;
          r.status = mda_pkg::StatSat;
        end
        vert_mem[it.vertex_index][j] = sum[31:0];
      end
    end
    r.x_out = vert_mem[it.vertex_index][0];
    r.y_out = vert_mem[it.vertex_index][1];
    r.z_out = vert_mem[it.vertex_index][2];
    return r;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    psel = 1'b1; pwrite = 1'b1; paddr = mda_pkg::PaddrW'({idx, 2'b00}); pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    case (idx)
      mda_pkg::RegPackedMode:  cfg_packed = val[0];
      mda_pkg::RegMorphWeight: cfg_weight = val[23:0];
      mda_pkg::RegPackedScale: cfg_scale = val;
      mda_pkg::RegVertexCount: cfg_count = val[12:0];
      default: ;
    endcase
  endtask

  // drive one item; optional typed-in expectation overrides the predictor
  task automatic send_item(mda_pkg::in_item_t it, bit has_exp, mda_pkg::out_item_t exp_r);
    mda_pkg::out_item_t p;
    @(negedge clk_i);
    in_item_i = it;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    p = morph_step(it);
    expected_q.insert(expected_q.size(), has_exp ? exp_r : p);
    n_items++;
    if (p.status == mda_pkg::StatSat) n_sat++;
    if (p.status == mda_pkg::StatOob) n_oob++;
    // keep valid high when another item follows in a burst
    if (!send_now) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [15:0] loaded_index();
    int k;
    for (int t = 0; t < 64; t++) begin
      k = $urandom_range(((cfg_count < Depth) ? cfg_count : Depth) - 1, 0);
      if (vert_loaded[k]) return 16'(k);
    end
    return 16'd0;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(4, 0))
      0: return 32'h7fff_ffff - $urandom_range(3, 0);
      1: return 32'h8000_0000 + $urandom_range(3, 0);
      2: return 32'($signed($urandom_range(16'hffff, 0)) - 32'sd32768);
      default: return $urandom;
    endcase
  endfunction

  // random item; ensures apply/read only hit loaded entries
  function automatic mda_pkg::in_item_t rand_item();
    mda_pkg::in_item_t it;
    int lim;
    lim = (cfg_count < Depth) ? cfg_count : Depth;
    it.x_value = rand_coord();
    it.y_value = rand_coord();
    it.z_value = rand_coord();
    it.operation = 2'($urandom_range(3, 0));
    if (lim == 0 || $urandom_range(15, 0) == 0) begin
      it.vertex_index = 16'($urandom_range(16'hffff, lim));
    end else if (it.operation == mda_pkg::OpLoad) begin
      it.vertex_index = 16'($urandom_range(lim - 1, 0));
    end else begin
      it.vertex_index = loaded_index();
      if (!vert_loaded[it.vertex_index]) it.operation = mda_pkg::OpLoad;
    end
    if (it.operation == mda_pkg::OpLoad && $urandom_range(1, 0)) begin
      it.operation = mda_pkg::OpApply;
    end
    if (it.operation == mda_pkg::OpApply && it.vertex_index < lim) begin
      if (!vert_loaded[it.vertex_index]) it.operation = mda_pkg::OpLoad;
    end
    return it;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    mda_pkg::out_item_t e;
    if (out_valid_o && !out_stall_i) begin
      n_results++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $realtime, out_item_o);
      end else begin
        e = expected_q.pop_front();
        if (out_item_o.x_out !== e.x_out || out_item_o.y_out !== e.y_out ||
            out_item_o.z_out !== e.z_out || out_item_o.status !== e.status) begin
          errors++;
          $display("%0t: mismatch expected %h actual %h", $realtime, e, out_item_o);
        end
      end
    end
  end

  // receiver stall pattern, with a long hold-off on request
  always @(negedge clk_i) begin
    if (!rst_ni) out_stall_i <= 1'b0;
    else if (hold_out) out_stall_i <= 1'b1;
    else out_stall_i <= ($urandom_range(7, 0) < 2);
  end

  // watchdog on progress
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  typedef struct {
    mda_pkg::in_item_t it;
    bit has_exp;
    mda_pkg::out_item_t res;
  } dir_row_t;

  initial begin
    dir_row_t rows[$];
    mda_pkg::in_item_t it;
    int burst;
    int phase_items;
    foreach (vert_loaded[i]) vert_loaded[i] = 1'b0;
    cfg_packed = 0; cfg_weight = 0; cfg_scale = 0; cfg_count = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // after reset vertex_count is zero: everything is out of bounds
    rows.insert(rows.size(), '{'{mda_pkg::OpRead, 16'd0, 32'd1, 32'd2, 32'd3}, 1,
                               '{0, 0, 0, mda_pkg::StatOob}});
    rows.insert(rows.size(), '{'{mda_pkg::OpLoad, 16'd0, 32'd1, 32'd2, 32'd3}, 1,
                               '{0, 0, 0, mda_pkg::StatOob}});
    foreach (rows[i]) send_item(rows[i].it, rows[i].has_exp, rows[i].res);
    drain();
    rows.delete();

    write_reg(mda_pkg::RegVertexCount, 32'd4096);
    write_reg(mda_pkg::RegMorphWeight, 32'h00ff_ffff);
    write_reg(mda_pkg::RegPackedScale, 32'h0100_0000);
    write_reg(mda_pkg::RegPackedMode, 32'd0);
    rows.insert(rows.size(),
                '{'{mda_pkg::OpLoad, 16'd0, 32'h7fff_ffff, 32'h8000_0000, 32'd0}, 1,
                  '{32'h7fff_ffff, 32'h8000_0000, 32'd0, mda_pkg::StatOk}});
    rows.insert(rows.size(),
                '{'{mda_pkg::OpLoad, 16'd4095, 32'h0001_0000, 32'hffff_0000, 32'd5}, 1,
                  '{32'h0001_0000, 32'hffff_0000, 32'd5, mda_pkg::StatOk}});
    rows.insert(rows.size(), '{'{mda_pkg::OpRead, 16'd4096, 32'd0, 32'd0, 32'd0}, 1,
                               '{0, 0, 0, mda_pkg::StatOob}});
    rows.insert(rows.size(), '{'{mda_pkg::OpApply, 16'hffff, 32'd7, 32'd7, 32'd7}, 1,
                               '{0, 0, 0, mda_pkg::StatOob}});
    rows.insert(rows.size(),
                '{'{mda_pkg::OpApply, 16'd0, 32'h8000_0000, 32'h7fff_ffff, 32'h1}, 0, '0});
    rows.insert(rows.size(),
                '{'{mda_pkg::OpApply, 16'd4095, 32'h7fff_ffff, 32'h8000_0000, 32'hffff},
                  0, '0});
    rows.insert(rows.size(), '{'{mda_pkg::OpRead, 16'd0, 32'd0, 32'd0, 32'd0}, 0, '0});
    rows.insert(rows.size(), '{'{2'd3, 16'd4095, 32'd0, 32'd0, 32'd0}, 0, '0});
    foreach (rows[i]) send_item(rows[i].it, rows[i].has_exp, rows[i].res);
    drain();
    rows.delete();

    write_reg(mda_pkg::RegPackedMode, 32'd1);
    write_reg(mda_pkg::RegMorphWeight, 32'h0080_0000);
    write_reg(mda_pkg::RegPackedScale, 32'hffff_ffff);
    rows.insert(rows.size(),
                '{'{mda_pkg::OpApply, 16'd0, 32'h0000_8000, 32'h0000_7fff, 32'hffff_ffff},
                  0, '0});
    rows.insert(rows.size(),
                '{'{mda_pkg::OpApply, 16'd4095, 32'h1234_7fff, 32'hffff_8000, 32'h0},
                  0, '0});
    rows.insert(rows.size(), '{'{mda_pkg::OpRead, 16'd4095, 32'd0, 32'd0, 32'd0}, 0, '0});
    foreach (rows[i]) send_item(rows[i].it, rows[i].has_exp, rows[i].res);
    drain();

    // random phases over a spread of settings, extremes included
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(mda_pkg::RegPackedMode, 32'(ph % 2));
      case (ph % 5)
        0: write_reg(mda_pkg::RegMorphWeight, 32'h0001_0000);
        1: write_reg(mda_pkg::RegMorphWeight, 32'h007f_ffff);
        2: write_reg(mda_pkg::RegMorphWeight, 32'h0080_0000);
        default: write_reg(mda_pkg::RegMorphWeight, $urandom);
      endcase
      write_reg(mda_pkg::RegPackedScale,
                (ph == 3) ? 32'hffff_ffff : (ph == 6) ? 32'd0 : $urandom);
      write_reg(mda_pkg::RegVertexCount, (ph == 2) ? 32'd0 : (ph == 5) ? 32'd8191 :
                (ph == 7) ? 32'd1 : 32'($urandom_range(64, 2)));
      phase_items = 150;
      while (phase_items > 0) begin
        burst = $urandom_range(12, 1);
        if (ph == 4 && phase_items == 150) fork
          begin
            hold_out = 1'b1;
            repeat (200) @(posedge clk_i);
            hold_out = 1'b0;
          end
        join_none
        for (int b = 0; b < burst && phase_items > 0; b++) begin
          it = rand_item();
          send_now = (b < burst - 1) && (phase_items > 1);
          send_item(it, 0, '0);
          phase_items--;
        end
        send_now = 1'b0;
        if (ph == 8 && phase_items < 75 && phase_items > 60) drain();
        else if ($urandom_range(1, 0)) repeat ($urandom_range(6, 1)) @(negedge clk_i);
      end
      drain();
    end

    $display("covered %0d items, %0d results, %0d saturated, %0d out of bounds",
             n_items, n_results, n_sat, n_oob);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
